@@ hdl/scl_pwm_pkg.sv @@
// ============================================================================
// Six-channel latched PWM package
// Shared widths, register indexes and command codes.
// ============================================================================
`default_nettype none

package scl_pwm_pkg;

    localparam int DUTY_W     = 32;
    localparam int CHAN_W     = 3;
    localparam int LEVELS_W   = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam int DEFAULT_CHANNELS    = 6;
    localparam int DEFAULT_COUNT_WIDTH = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_DIVIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT = 1'd1;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_DUTY = 1'b1;

endpackage

`default_nettype wire

@@ hdl/scl_pwm_if.sv @@
// ============================================================================
// Six-channel latched PWM channel interfaces
// Valid/ready channels for command items and result items.
// ============================================================================
`default_nettype none

interface scl_pwm_cmd_if import scl_pwm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [CHAN_W-1:0] channel;
    logic [DUTY_W-1:0] duty_value;

    modport source (output valid, output action, output channel, output duty_value,
                    input ready);
    modport sink   (input valid, input action, input channel, input duty_value,
                    output ready);
endinterface

interface scl_pwm_res_if import scl_pwm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LEVELS_W-1:0] pwm_levels;
    logic                period_start;

    modport source (output valid, output pwm_levels, output period_start, input ready);
    modport sink   (input valid, input pwm_levels, input period_start, output ready);
endinterface

`default_nettype wire

@@ hdl/six_channel_latched_pwm_core.sv @@
// ============================================================================
// Six-channel latched PWM core
// Single-edge PWM timer with prescaler and shadow match registers.
//
// Each command on cmd is either one clock tick or a duty write for a channel.
// Every command produces exactly one transfer on result, carrying the channel
// levels after the command and a flag that marks a timer wrap.
// A command is held in an input register and processed once the result
// register is free or being emptied; its result is registered in the
// result register and is held there until the result transfer happens.
// One command per cycle is sustained while result is not stalled,
// as the prescaler, timer and matches are all updated in each step.
// When result is stalled, one more command is accepted into the input
// register; after that cmd.ready drops until the result transfer happens.
// The configuration port sets the divisor and the period; write it only
// while no command is in flight. Reset clears all counters and matches,
// sets the divisor to one, the period to zero and drives all levels low.
// ============================================================================
`default_nettype none

module six_channel_latched_pwm_core import scl_pwm_pkg::*;
#(
    parameter int CHANNELS    = DEFAULT_CHANNELS,
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    scl_pwm_cmd_if.sink                cmd,
    scl_pwm_res_if.source              result
);

    logic [CFG_DATA_W-1:0]  div_m1_reg;
    logic [COUNT_WIDTH-1:0] period_reg;

    logic                   cmd_valid_reg;
    logic                   cmd_action_reg;
    logic [CHAN_W-1:0]      cmd_channel_reg;
    logic [COUNT_WIDTH-1:0] cmd_duty_reg;

    logic [CFG_DATA_W-1:0]  prescale_reg, prescale_next;
    logic [COUNT_WIDTH-1:0] timer_reg, timer_next;
    logic [COUNT_WIDTH-1:0] shadow_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0] shadow_next [CHANNELS];
    logic [COUNT_WIDTH-1:0] active_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0] active_next [CHANNELS];
    logic [CHANNELS-1:0]    latch_reg, latch_next;
    logic [CHANNELS-1:0]    levels_reg, levels_next;

    logic                   out_valid_reg;
    logic [LEVELS_W-1:0]    out_levels_reg;
    logic                   out_start_reg;

    logic                   cmd_xfer;
    logic                   do_step;
    logic                   advance;
    logic                   wrap;
    logic                   chan_ok;
    logic [COUNT_WIDTH-1:0] timer_inc;

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign do_step  = cmd_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready = !cmd_valid_reg || do_step;

    assign advance   = (cmd_action_reg == ACTION_TICK) && (prescale_reg >= div_m1_reg);
    assign wrap      = advance && (timer_reg >= period_reg);
    assign timer_inc = timer_reg + 1'b1;
    assign chan_ok   = (cmd_action_reg == ACTION_DUTY) && (cmd_channel_reg != '0)
                       && (cmd_channel_reg <= CHAN_W'(CHANNELS));

    always_comb
    begin
        prescale_next = prescale_reg;
        timer_next    = timer_reg;
        latch_next    = latch_reg;
        levels_next   = levels_reg;
        for (int n = 0; n < CHANNELS; n++)
        begin
            shadow_next[n] = shadow_reg[n];
            active_next[n] = active_reg[n];
        end
        if (cmd_action_reg == ACTION_TICK)
        begin
            if (!advance)
            begin
                prescale_next = prescale_reg + 1'b1;
            end
            else if (wrap)
            begin
                prescale_next = '0;
                timer_next    = '0;
                latch_next    = '0;
                levels_next   = '1;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (latch_reg[n])
                    begin
                        active_next[n] = shadow_reg[n];
                    end
                end
            end
            else
            begin
                prescale_next = '0;
                timer_next    = timer_inc;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if ((active_reg[n] != '0) && (timer_inc == active_reg[n]))
                    begin
                        levels_next[n] = 1'b0;
                    end
                end
            end
        end
        else if (chan_ok)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                if (cmd_channel_reg == CHAN_W'(n + 1))
                begin
                    shadow_next[n] = cmd_duty_reg;
                    latch_next[n]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_m1_reg <= '0;
            period_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CLOCK_DIVIDE:
                begin
                    div_m1_reg <= (cfg_wdata == '0) ? '0 : cfg_wdata - 1'b1;
                end
                REG_PERIOD_COUNT:
                begin
                    period_reg <= cfg_wdata[COUNT_WIDTH-1:0];
                end
                default:
                begin
                    period_reg <= period_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (do_step)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            cmd_action_reg  <= cmd.action;
            cmd_channel_reg <= cmd.channel;
            cmd_duty_reg    <= cmd.duty_value[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            timer_reg    <= '0;
            latch_reg    <= '0;
            levels_reg   <= '0;
            for (int n = 0; n < CHANNELS; n++)
            begin
                shadow_reg[n] <= '0;
                active_reg[n] <= '0;
            end
        end
        else if (do_step)
        begin
            prescale_reg <= prescale_next;
            timer_reg    <= timer_next;
            latch_reg    <= latch_next;
            levels_reg   <= levels_next;
            for (int n = 0; n < CHANNELS; n++)
            begin
                shadow_reg[n] <= shadow_next[n];
                active_reg[n] <= active_next[n];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_levels_reg <= LEVELS_W'(levels_next);
            out_start_reg  <= wrap;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pwm_levels   = out_levels_reg;
    assign result.period_start = out_start_reg;

    // A wrap restarts the timer and consumes every pending shadow update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && wrap) |=> (timer_reg == '0) && (latch_reg == '0))
        else $error("wrap did not clear timer and pending latches");

    // A reported period start always shows every channel high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.period_start) |->
            (result.pwm_levels[CHANNELS-1:0] == {CHANNELS{1'b1}}))
        else $error("period start with a channel low");

    // Outside a wrap, a level can only fall.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && !wrap) |=> ((levels_reg & ~$past(levels_reg)) == '0))
        else $error("level rose without a wrap");

endmodule

`default_nettype wire
